/* rtl/pbo_pkg.sv */
// pbo_pkg: shared constants, types and helpers of the polyBLEP oscillator.
// Holds the controller/datapath command and status structs and the sine ROM builder.
// No dependencies.
package pbo_pkg;

   // Phase and waveform formats
   localparam int PHASE_BITS  = 32;
   localparam int FRAC_BITS   = 14;
   localparam int TAB_N       = 1024;
   localparam int TAB_AW      = 10;
   localparam int DT_W        = 33;  // step can exceed one cycle at low sample rates
   localparam int FREQ_W      = 22;
   localparam int SR_W        = 18;
   localparam int PW_W        = 16;
   localparam int NUM_W       = FREQ_W + PHASE_BITS - 8;  // dividend of the step division
   localparam int CNT_W       = 6;
   localparam int WIDE_W      = 19;  // signed working width of waveform sums

   // Clamp limits
   localparam logic [FREQ_W-1:0] FREQ_MIN = 22'd2560;
   localparam logic [FREQ_W-1:0] FREQ_MAX = 22'd3072000;
   localparam logic [SR_W-1:0]   SR_MIN   = 18'd8000;
   localparam logic [SR_W-1:0]   SR_MAX   = 18'd192000;
   localparam logic [PW_W-1:0]   PW_MIN   = 16'd3277;
   localparam logic [PW_W-1:0]   PW_MAX   = 16'd62259;

   // Register reset values and indexes
   localparam logic [SR_W-1:0] SR_RESET = 18'd44100;
   localparam logic [PW_W-1:0] PW_RESET = 16'd31457;
   localparam logic REG_SAMPLE_RATE = 1'b0;
   localparam logic REG_PULSE_WIDTH = 1'b1;

   // polyBLEP correction kinds
   localparam logic [1:0] BLEP_NONE = 2'd0;
   localparam logic [1:0] BLEP_LOW  = 2'd1;
   localparam logic [1:0] BLEP_HIGH = 2'd2;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef logic [FRAC_BITS:0] sine_rom_type [0:TAB_N];

   // Controller to datapath
   typedef struct packed {
      logic load_item;
      logic div_load_dt;
      logic div_load_blep;
      logic blep_sel;      // 0: blep of the phase, 1: blep of the shifted phase
      logic phase_upd;
      logic sq_cap;
      logic rom_sel;       // 0: main phase, 1: sub phase
      logic sin_main_cap;
      logic out_load;
   } pbo_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_busy;
   } pbo_status_type;

   // Shift-and-subtract long division, used only while building tables
   function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], num[b]};
         if (r >= den) begin
            r = r - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Quarter-wave sine table, Taylor series at Q30, rounded to FRAC_BITS
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      longint unsigned x;
      longint unsigned term;
      longint unsigned s;
      longint sum;
      longint unsigned dv;
      for (int i = 0; i <= TAB_N; i++) begin
         x = (longint'(i) * HALF_PI_Q30) >> TAB_AW;
         term = x;
         sum = longint'(x);
         for (int n = 1; n <= 10; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            dv = longint'(2 * n) * longint'(2 * n + 1);
            term = udiv64(term, dv);
            if (n % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
         s = longint'(sum);
         s = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
         rom[i] = s[FRAC_BITS:0];
      end
      return rom;
   endfunction

   // Saturate a working sum to 16 bits
   function automatic logic signed [15:0] sat16(logic signed [WIDE_W-1:0] v);
      if (v > 19'sd32767) return 16'sh7FFF;
      if (v < -19'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

endpackage

/* rtl/polyblep_oscillator_top.sv */
// polyblep_oscillator_top: top level of the band-limited oscillator.
// Instantiates pbo_ctrl and pbo_datapath; depends on pbo_pkg.
//
// One request transaction is one sample tick (frequency in Hz with 8 fraction bits and a
// restart flag); it yields one response transaction of five Q2.14 waveforms. The block
// works on one tick at a time: its time from acceptance to the response is set by the
// shared one-bit-per-cycle divider (46 steps for the phase step, then 14 steps for each
// of the two polyBLEP terms) plus the sine ROM reads. A finished response waits in its
// register while the next tick is taken. Sample rate and pulse width are to be written
// through the csr port only while the block is idle; the block itself does not enforce this.
module polyblep_oscillator_top import pbo_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [23:0]     req_tdata,   // [21:0] freq_q8, [22] restart, [23] zero
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [79:0]     rsp_tdata,   // sine_out, triangle_out, sub_sine_out, saw_out,
                                        // pulse_out, 16 bits each from bit 0 up
   input  logic            csr_we,
   input  logic            csr_index,
   input  logic [SR_W-1:0] csr_wdata
);

   pbo_cmd_type    cmd;
   pbo_status_type status;

   pbo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pbo_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

   // Busy right after a transaction is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a tick is in progress");

   // The result register is loaded only when free
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwritten before it was taken");

   // No division, of the phase step or of a polyBLEP term, starts over a running one
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_load_blep || cmd.div_load_dt) |-> !status.div_busy)
      else $error("divider restarted while busy");

endmodule

/* rtl/pbo_ctrl.sv */
// pbo_ctrl: sequencer of the polyBLEP oscillator.
// Steps the datapath through step division, phase update, two polyBLEP terms, sine reads.
// Depends on pbo_pkg.
module pbo_ctrl import pbo_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  pbo_status_type status,
   output pbo_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_WAIT_DT = 4'd1;
   localparam logic [3:0] S_PHASE   = 4'd2;
   localparam logic [3:0] S_B1_SET  = 4'd3;
   localparam logic [3:0] S_B1_WAIT = 4'd4;
   localparam logic [3:0] S_B1_SQ   = 4'd5;
   localparam logic [3:0] S_B2_SET  = 4'd6;
   localparam logic [3:0] S_B2_WAIT = 4'd7;
   localparam logic [3:0] S_B2_SQ   = 4'd8;
   localparam logic [3:0] S_SIN_M   = 4'd9;
   localparam logic [3:0] S_SIN_S   = 4'd10;
   localparam logic [3:0] S_OUT     = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               cmd.div_load_dt = 1'b1;
               state_in = S_WAIT_DT;
            end
         end
         S_WAIT_DT: begin
            if (!status.div_busy) state_in = S_PHASE;
         end
         S_PHASE: begin
            cmd.phase_upd = 1'b1;
            state_in = S_B1_SET;
         end
         S_B1_SET: begin
            cmd.div_load_blep = 1'b1;
            state_in = S_B1_WAIT;
         end
         S_B1_WAIT: begin
            if (!status.div_busy) state_in = S_B1_SQ;
         end
         S_B1_SQ: begin
            cmd.sq_cap = 1'b1;
            state_in = S_B2_SET;
         end
         S_B2_SET: begin
            cmd.blep_sel = 1'b1;
            cmd.div_load_blep = 1'b1;
            state_in = S_B2_WAIT;
         end
         S_B2_WAIT: begin
            cmd.blep_sel = 1'b1;
            if (!status.div_busy) state_in = S_B2_SQ;
         end
         S_B2_SQ: begin
            cmd.blep_sel = 1'b1;
            cmd.sq_cap = 1'b1;
            state_in = S_SIN_M;
         end
         S_SIN_M: begin
            state_in = S_SIN_S;
         end
         S_SIN_S: begin
            cmd.rom_sel = 1'b1;
            cmd.sin_main_cap = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            cmd.rom_sel = 1'b1;
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/pbo_datapath.sv */
// pbo_datapath: registers, shared bit-serial divider, squarer, sine ROM and output register.
// Driven by pbo_ctrl through pbo_cmd_type; reports divider status.
// Depends on pbo_pkg.
module pbo_datapath import pbo_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [23:0]       req_tdata,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [SR_W-1:0]   csr_wdata,
   input  pbo_cmd_type       cmd,
   output pbo_status_type    status,
   output logic [79:0]       rsp_tdata
);

   localparam sine_rom_type SINE_ROM = build_sine_rom();
   localparam logic [PHASE_BITS:0] PHASE_ONE = {1'b1, {PHASE_BITS{1'b0}}};
   localparam logic [PHASE_BITS-1:0] PHASE_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};
   localparam logic signed [WIDE_W-1:0] ONE_Q = 19'sd16384;

   // Configuration registers
   logic [SR_W-1:0] sr_cfg_ff;
   logic [PW_W-1:0] pw_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_cfg_ff <= SR_RESET;
         pw_cfg_ff <= PW_RESET;
      end else if (csr_we) begin
         if (csr_index == REG_SAMPLE_RATE) sr_cfg_ff <= csr_wdata;
         else pw_cfg_ff <= csr_wdata[PW_W-1:0];
      end
   end

   // Input clamps
   logic [FREQ_W-1:0] freq_clamp;
   logic [SR_W-1:0]   sr_clamp;
   logic [PW_W-1:0]   pw_clamp;

   always_comb begin
      freq_clamp = req_tdata[FREQ_W-1:0];
      if (freq_clamp < FREQ_MIN) freq_clamp = FREQ_MIN;
      if (freq_clamp > FREQ_MAX) freq_clamp = FREQ_MAX;
      sr_clamp = sr_cfg_ff;
      if (sr_clamp < SR_MIN) sr_clamp = SR_MIN;
      if (sr_clamp > SR_MAX) sr_clamp = SR_MAX;
      pw_clamp = pw_cfg_ff;
      if (pw_clamp < PW_MIN) pw_clamp = PW_MIN;
      if (pw_clamp > PW_MAX) pw_clamp = PW_MAX;
   end

   logic            restart_ff;
   logic [PW_W-1:0] pw_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         restart_ff <= req_tdata[FREQ_W];
         pw_ff <= pw_clamp;
      end
   end

   // Shared restoring divider, one quotient bit per cycle
   logic [DT_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0] dvd_ff, dvd_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DT_W-1:0]  den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DT_W:0]    trial;
   logic [DT_W:0]    trial_sub;
   logic             trial_ge;

   // polyBLEP operand selection
   logic [DT_W-1:0]       dt_ff;
   logic [PHASE_BITS-1:0] main_ff, sub_ff;
   logic [PHASE_BITS-1:0] pwp;
   logic [PHASE_BITS-1:0] blep_t;
   logic [DT_W:0]         blep_sum;
   logic [DT_W-1:0]       blep_num;
   logic [1:0]            blep_kind;
   logic [1:0]            mode_ff;

   assign pwp = {pw_ff, {(PHASE_BITS-PW_W){1'b0}}};

   always_comb begin
      blep_t = cmd.blep_sel ? (main_ff - pwp) : main_ff;
      blep_sum = {2'b00, blep_t} + {1'b0, dt_ff};
      blep_num = '0;
      blep_kind = BLEP_NONE;
      if ({1'b0, blep_t} < dt_ff) begin
         blep_kind = BLEP_LOW;
         blep_num = {1'b0, blep_t};
      end else if (blep_sum > {1'b0, PHASE_ONE}) begin
         blep_kind = BLEP_HIGH;
         blep_num = DT_W'(blep_sum - {1'b0, PHASE_ONE});
      end
   end

   always_comb begin
      trial = {rem_ff, dvd_ff[NUM_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      trial_ge = (trial >= {1'b0, den_ff});
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      priority if (cmd.div_load_dt) begin
         rem_in = '0;
         dvd_in = {freq_clamp, {(PHASE_BITS-8){1'b0}}};
         den_in = {{(DT_W-SR_W){1'b0}}, sr_clamp};
         cnt_in = CNT_W'(NUM_W);
      end else if (cmd.div_load_blep) begin
         rem_in = blep_num;
         dvd_in = '0;
         den_in = dt_ff;
         cnt_in = CNT_W'(FRAC_BITS);
      end else if (cnt_ff != '0) begin
         rem_in = trial_ge ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
         dvd_in = {dvd_ff[NUM_W-2:0], 1'b0};
         quo_in = {quo_ff[NUM_W-2:0], trial_ge};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign status.div_busy = (cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (cmd.div_load_blep) mode_ff <= blep_kind;
   end

   // Phase accumulators
   logic [PHASE_BITS-1:0] main_base, sub_base;

   assign main_base = restart_ff ? '0 : main_ff;
   assign sub_base = restart_ff ? '0 : sub_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_ff <= '0;
         sub_ff <= '0;
      end else if (cmd.phase_upd) begin
         main_ff <= main_base + quo_ff[PHASE_BITS-1:0];
         sub_ff <= sub_base + quo_ff[DT_W-1:1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.phase_upd) dt_ff <= quo_ff[DT_W-1:0];
   end

   // Correction squarer
   logic [FRAC_BITS-1:0] u;
   logic [FRAC_BITS:0]   sq_op;
   logic [2*FRAC_BITS+1:0] sq;
   logic signed [15:0]   corr;
   logic signed [15:0]   blep1_ff, blep2_ff;

   always_comb begin
      u = quo_ff[FRAC_BITS-1:0];
      sq_op = (mode_ff == BLEP_LOW) ? ((FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, u})
                                    : {1'b0, u};
      sq = sq_op * sq_op;
      unique case (mode_ff)
         BLEP_LOW:  corr = -$signed(16'(sq >> FRAC_BITS));
         BLEP_HIGH: corr = $signed(16'(sq >> FRAC_BITS));
         default:   corr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_cap) begin
         if (cmd.blep_sel) blep2_ff <= corr;
         else blep1_ff <= corr;
      end
   end

   // Quarter-wave sine ROM, registered read
   logic [PHASE_BITS-1:0] rom_ph;
   logic [TAB_AW+1:0]     rom_k;
   logic [TAB_AW:0]       rom_addr;
   logic [FRAC_BITS:0]    rom_q_ff;
   logic                  rom_neg_ff;
   logic signed [15:0]    rom_val;
   logic signed [15:0]    sin_main_ff;

   always_comb begin
      rom_ph = cmd.rom_sel ? sub_ff : main_ff;
      rom_k = rom_ph[PHASE_BITS-1 -: TAB_AW+2];
      rom_addr = rom_k[TAB_AW] ? ((TAB_AW+1)'(TAB_N) - {1'b0, rom_k[TAB_AW-1:0]})
                               : {1'b0, rom_k[TAB_AW-1:0]};
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= SINE_ROM[rom_addr];
      rom_neg_ff <= rom_k[TAB_AW+1];
   end

   assign rom_val = rom_neg_ff ? -$signed({1'b0, rom_q_ff}) : $signed({1'b0, rom_q_ff});

   always_ff @(posedge clock) begin
      if (cmd.sin_main_cap) sin_main_ff <= rom_val;
   end

   // Waveform assembly
   logic [PHASE_BITS-1:0]     tri_abs;
   logic signed [WIDE_W-1:0]  tri_w, saw_w, pulse_w;

   always_comb begin
      tri_abs = (main_ff >= PHASE_HALF) ? (main_ff - PHASE_HALF) : (PHASE_HALF - main_ff);
      tri_w = $signed({3'b000, tri_abs[PHASE_BITS-1 -: 16]}) - ONE_Q;
      saw_w = $signed({4'b0000, main_ff[PHASE_BITS-1 -: 15]}) - ONE_Q
              - WIDE_W'(blep1_ff);
      pulse_w = ((main_ff < pwp) ? ONE_Q : -ONE_Q) + WIDE_W'(blep1_ff)
                - WIDE_W'(blep2_ff);
   end

   // Result register: sine, triangle, sub sine, saw, pulse from the low bits up
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_tdata <= {sat16(pulse_w), sat16(saw_w), rom_val, sat16(tri_w), sin_main_ff};
      end
   end

endmodule
